/* rtl/lcv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcv_pkg
// Shared constants, codes and control types of the loop consensus vote unit.
// ----------------------------------------------------------------------------
package lcv_pkg;

   localparam int MAX_PAIRS = 16;
   localparam int IDX_W     = $clog2(MAX_PAIRS);
   localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
   localparam int STEP_W    = $clog2(MAX_PAIRS + 2);

   localparam int RES_W     = 16;
   localparam int KEY_W     = 17;
   localparam int SUM_W     = 18;
   localparam int CNT_OUT_W = 5;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE    = 1'd1;

   localparam logic [CSR_W-1:0] DISTANCE_RESET = 16'd1000;
   localparam logic [CSR_W-1:0] ANGLE_RESET    = 16'd175;

   localparam logic [1:0] DEC_COMMIT = 2'd0;
   localparam logic [1:0] DEC_DEFER  = 2'd1;
   localparam logic [1:0] DEC_REJECT = 2'd2;

   localparam logic [2:0] RSN_CONSENSUS     = 3'd0;
   localparam logic [2:0] RSN_CONTRADICTION = 3'd1;
   localparam logic [2:0] RSN_INSUFFICIENT  = 3'd2;
   localparam logic [2:0] RSN_UNSTABLE      = 3'd3;
   localparam logic [2:0] RSN_WEAK          = 3'd4;

   typedef struct packed {
      logic             req_ready;
      logic [IDX_W-1:0] rd_addr;
      logic             clear_acc;
      logic             take_cand;
      logic             compare;
      logic             finish_cand;
      logic             pass;
      logic             latch_med;
      logic             latch_mad;
      logic             load_out;
   } lcv_cmd_type;

   typedef struct packed {
      logic             last_fire;
      logic [CNT_W-1:0] fill;
      logic             out_busy;
   } lcv_status_type;

endpackage

/* rtl/lcv_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcv_req_if / lcv_rsp_if
// Valid/ready channels for pair records and verdicts.
// ----------------------------------------------------------------------------
interface lcv_req_if;
   logic        valid;
   logic        ready;
   logic        pair_valid;
   logic        pair_converged;
   logic        deltas_finite;
   logic signed [4:0] pair_offset;
   logic [15:0] translation_residual;
   logic [15:0] rotation_residual;
   logic        last_pair;

   modport source (output valid, pair_valid, pair_converged, deltas_finite, pair_offset,
                   translation_residual, rotation_residual, last_pair, input ready);
   modport sink (input valid, pair_valid, pair_converged, deltas_finite, pair_offset,
                 translation_residual, rotation_residual, last_pair, output ready);
endinterface

interface lcv_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  decision;
   logic [2:0]  reason_code;
   logic [4:0]  valid_count;
   logic [4:0]  left_count;
   logic [4:0]  right_count;
   logic [4:0]  conflict_count;
   logic [16:0] median_translation;
   logic [16:0] median_rotation;
   logic [17:0] spread_translation;
   logic [17:0] spread_rotation;
   logic        stats_valid;

   modport source (output valid, decision, reason_code, valid_count, left_count, right_count,
                   conflict_count, median_translation, median_rotation,
                   spread_translation, spread_rotation, stats_valid, input ready);
   modport sink (input valid, decision, reason_code, valid_count, left_count, right_count,
                 conflict_count, median_translation, median_rotation,
                 spread_translation, spread_rotation, stats_valid, output ready);
endinterface

/* rtl/lcv_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcv_ctrl
// Sequencer: record loading, two rank-count passes, verdict hand-off.
// ----------------------------------------------------------------------------
module lcv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  lcv_pkg::lcv_status_type status,
   output lcv_pkg::lcv_cmd_type    cmd
);
   import lcv_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_START, ST_SCAN, ST_MID, ST_FIN} state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  cand_ff;
   logic [STEP_W-1:0] step_ff;
   logic              pass_ff;

   always_comb begin
      cmd             = '0;
      cmd.req_ready   = (state_ff == ST_IDLE);
      cmd.pass        = pass_ff;
      cmd.rd_addr     = (step_ff == '0) ? cand_ff : IDX_W'(step_ff - 1'b1);
      if (state_ff == ST_SCAN) begin
         cmd.clear_acc   = (step_ff == '0);
         cmd.take_cand   = (step_ff == STEP_W'(1));
         cmd.compare     = (step_ff >= STEP_W'(2)) && (step_ff <= status.fill);
         cmd.finish_cand = (step_ff == status.fill + 1'b1);
      end
      cmd.latch_med = (state_ff == ST_MID) && !pass_ff;
      cmd.latch_mad = (state_ff == ST_MID) && pass_ff;
      cmd.load_out  = (state_ff == ST_FIN) && !status.out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cand_ff  <= '0;
         step_ff  <= '0;
         pass_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (status.last_fire) begin
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               cand_ff <= '0;
               step_ff <= '0;
               pass_ff <= 1'b0;
               state_ff <= (status.fill == '0) ? ST_FIN : ST_SCAN;
            end
            ST_SCAN: begin
               if (step_ff == status.fill + 1'b1) begin
                  step_ff <= '0;
                  if (CNT_W'(cand_ff) + 1'b1 == status.fill) begin
                     cand_ff  <= '0;
                     state_ff <= ST_MID;
                  end else begin
                     cand_ff <= cand_ff + 1'b1;
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_MID: begin
               if (!pass_ff) begin
                  pass_ff  <= 1'b1;
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!status.out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* rtl/lcv_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcv_datapath
// Tallies, residual stores, rank-count selection, verdict register.
// ----------------------------------------------------------------------------
module lcv_datapath (
   input  logic                       clock,
   input  logic                       reset,
   lcv_req_if.sink                    req_port,
   lcv_rsp_if.source                  rsp_port,
   input  logic                       csr_we,
   input  logic [lcv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lcv_pkg::CSR_W-1:0]  csr_wdata,
   input  lcv_pkg::lcv_cmd_type       cmd,
   output lcv_pkg::lcv_status_type    status
);
   import lcv_pkg::*;

   function automatic logic [KEY_W-1:0] make_key(input logic [RES_W-1:0] x,
                                                 input logic [KEY_W-1:0] m,
                                                 input logic            dev);
      logic [KEY_W-1:0] d;
      d = {x, 1'b0};
      if (!dev) return d;
      return (d >= m) ? d - m : m - d;
   endfunction

   logic [CSR_W-1:0] dist_ff, angle_ff;
   logic [CNT_W-1:0] fill_ff, valid_ff, left_ff, right_ff, contra_ff, support_ff;

   logic [RES_W-1:0] mem_t [MAX_PAIRS];
   logic [RES_W-1:0] mem_r [MAX_PAIRS];
   logic [RES_W-1:0] rd_ff   [2];
   logic [KEY_W-1:0] cand_ff [2];
   logic [CNT_W-1:0] less_ff [2];
   logic [CNT_W-1:0] leq_ff  [2];
   logic [KEY_W-1:0] lo_ff   [2];
   logic [KEY_W-1:0] hi_ff   [2];
   logic [KEY_W-1:0] med_ff  [2];
   logic [SUM_W-1:0] mad_ff  [2];

   logic [KEY_W-1:0] key     [2];
   logic             lt      [2];
   logic             le      [2];
   logic [CNT_W-1:0] less_in [2];
   logic [CNT_W-1:0] leq_in  [2];
   logic [SUM_W-1:0] sum     [2];

   logic accept, taken, good, wr, stats;
   logic [CNT_W-1:0] klo, khi;
   logic enough, sides, tight, stable;
   logic [1:0] dec_in;
   logic [2:0] rsn_in;
   logic rsp_valid_ff;

   assign accept = req_port.valid && cmd.req_ready;
   assign taken  = req_port.pair_valid && (int'(valid_ff) < MAX_PAIRS);
   assign good   = req_port.pair_converged && req_port.deltas_finite;
   assign wr     = accept && taken && good && (int'(fill_ff) < MAX_PAIRS);
   assign req_port.ready = cmd.req_ready;

   assign status.last_fire = accept && req_port.last_pair;
   assign status.fill      = fill_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_port.ready;

   assign klo = (fill_ff - 1'b1) >> 1;
   assign khi = fill_ff >> 1;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         key[l]     = make_key(rd_ff[l], med_ff[l], cmd.pass);
         lt[l]      = key[l] < cand_ff[l];
         le[l]      = key[l] <= cand_ff[l];
         less_in[l] = less_ff[l] + CNT_W'(lt[l]);
         leq_in[l]  = leq_ff[l] + CNT_W'(le[l]);
         sum[l]     = SUM_W'(lo_ff[l]) + SUM_W'(hi_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff  <= DISTANCE_RESET;
         angle_ff <= ANGLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DISTANCE: dist_ff  <= csr_wdata;
            CSR_ANGLE:    angle_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         fill_ff    <= '0;
         valid_ff   <= '0;
         left_ff    <= '0;
         right_ff   <= '0;
         contra_ff  <= '0;
         support_ff <= '0;
      end else if (accept && taken) begin
         valid_ff <= valid_ff + 1'b1;
         if (req_port.pair_offset < 0) begin
            left_ff <= left_ff + 1'b1;
         end else if (req_port.pair_offset != 0) begin
            right_ff <= right_ff + 1'b1;
         end
         if (!good) begin
            contra_ff <= contra_ff + 1'b1;
         end else begin
            if (wr) fill_ff <= fill_ff + 1'b1;
            if ({1'b0, req_port.translation_residual} <= {dist_ff, 1'b0} &&
                {1'b0, req_port.rotation_residual} <= {angle_ff, 1'b0}) begin
               support_ff <= support_ff + 1'b1;
            end
            if ({2'b0, req_port.translation_residual} > {dist_ff, 2'b0} ||
                {2'b0, req_port.rotation_residual} > {angle_ff, 2'b0}) begin
               contra_ff <= contra_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_t[fill_ff[IDX_W-1:0]] <= req_port.translation_residual;
         mem_r[fill_ff[IDX_W-1:0]] <= req_port.rotation_residual;
      end
      rd_ff[0] <= mem_t[cmd.rd_addr];
      rd_ff[1] <= mem_r[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         if (cmd.take_cand) cand_ff[l] <= key[l];
         if (cmd.clear_acc) begin
            less_ff[l] <= '0;
            leq_ff[l]  <= '0;
         end else if (cmd.compare) begin
            less_ff[l] <= less_in[l];
            leq_ff[l]  <= leq_in[l];
         end
         if (cmd.finish_cand) begin
            if (less_in[l] <= klo && klo < leq_in[l]) lo_ff[l] <= cand_ff[l];
            if (less_in[l] <= khi && khi < leq_in[l]) hi_ff[l] <= cand_ff[l];
         end
         if (cmd.latch_med) med_ff[l] <= sum[l][KEY_W:1];
         if (cmd.latch_mad) mad_ff[l] <= sum[l];
      end
   end

   assign stats  = (fill_ff != '0);
   assign enough = int'(valid_ff) >= 4;
   assign sides  = (left_ff != '0) || (right_ff != '0);
   assign tight  = stats && ({1'b0, med_ff[0]} <= {dist_ff, 2'b0}) &&
                   ({1'b0, med_ff[1]} <= {angle_ff, 2'b0});
   assign stable = !stats || ((mad_ff[0] <= {dist_ff, 2'b0}) &&
                              (mad_ff[1] <= {angle_ff, 2'b0}));

   always_comb begin
      if (enough && int'(contra_ff) > (int'(valid_ff) >> 1)) begin
         dec_in = DEC_REJECT;
         rsn_in = RSN_CONTRADICTION;
      end else if (enough && sides && int'(support_ff) >= ((3 * int'(valid_ff) + 3) >> 2) &&
                   tight && stable && contra_ff == '0) begin
         dec_in = DEC_COMMIT;
         rsn_in = RSN_CONSENSUS;
      end else begin
         dec_in = DEC_DEFER;
         if (!enough)              rsn_in = RSN_INSUFFICIENT;
         else if (contra_ff != '0) rsn_in = RSN_UNSTABLE;
         else                      rsn_in = RSN_WEAK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_port.decision            <= dec_in;
         rsp_port.reason_code         <= rsn_in;
         rsp_port.valid_count         <= CNT_OUT_W'(valid_ff);
         rsp_port.left_count          <= CNT_OUT_W'(left_ff);
         rsp_port.right_count         <= CNT_OUT_W'(right_ff);
         rsp_port.conflict_count      <= CNT_OUT_W'(contra_ff);
         rsp_port.median_translation  <= stats ? med_ff[0] : '0;
         rsp_port.median_rotation     <= stats ? med_ff[1] : '0;
         rsp_port.spread_translation  <= stats ? mad_ff[0] : '0;
         rsp_port.spread_rotation     <= stats ? mad_ff[1] : '0;
         rsp_port.stats_valid         <= stats;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;

endmodule

/* rtl/loop_consensus_vote_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loop_consensus_vote_unit
// Neighbor-pair consensus vote for a loop closure candidate.
// ----------------------------------------------------------------------------
// A pair record is taken whenever the unit is idle. The record flagged last_pair
// closes the set: the verdict beat then follows from two rank-count passes
// (median, then deviation; skipped with no measured pair) that walk the residual
// stores through a single read port. No record is taken until the verdict is
// loaded. The next set can load while the verdict waits on rsp_port; a second
// verdict stalls until the first one has been taken.
module loop_consensus_vote_unit (
   input  logic                          clock,
   input  logic                          reset,
   lcv_req_if.sink                       req_port,
   lcv_rsp_if.source                     rsp_port,
   input  logic                          csr_we,
   input  logic [lcv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lcv_pkg::CSR_W-1:0]     csr_wdata
);
   import lcv_pkg::*;

   lcv_cmd_type    cmd;
   lcv_status_type status;

   lcv_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lcv_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .rsp_port  (rsp_port),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* tb/loop_consensus_vote_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loop_consensus_vote_unit_tb
// Self-checking bench for the loop consensus vote unit. Pair-record sets are
// driven over the request channel with random gaps; each verdict beat is
// compared field by field against an in-bench vote predictor. Thresholds are
// reprogrammed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module loop_consensus_vote_unit_tb;
   import lcv_pkg::*;

   typedef struct {
      logic              pv, pc, pf;
      logic signed [4:0] off;
      logic [15:0]       tr, rr;
      logic              last;
   } pair_rec_type;

   typedef struct {
      logic [1:0]  dec;
      logic [2:0]  rsn;
      logic [4:0]  vcnt, lcnt, rcnt, ccnt;
      logic [16:0] med_t, med_r;
      logic [17:0] mad_t, mad_r;
      logic        stats;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DISTANCE;
   logic [CSR_W-1:0] csr_wdata = '0;

   lcv_req_if req_if();
   lcv_rsp_if rsp_if();

   loop_consensus_vote_unit u_top (
      .clock(clock), .reset(reset), .req_port(req_if.sink), .rsp_port(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   pair_rec_type pending_pairs[$];
   verdict_type  expected_verdicts[$];
   int           errors = 0;
   bit           hold_rsp = 0;
   bit           wait_drain = 0;

   // predictor state
   int unsigned dist_thr = DISTANCE_RESET, ang_thr = ANGLE_RESET;
   logic [15:0] t_store[MAX_PAIRS], r_store[MAX_PAIRS];
   int unsigned n_meas, n_valid, n_left, n_right, n_contra, n_support;

   task automatic enqueue_pair(input pair_rec_type p);
      pending_pairs.insert(pending_pairs.size(), p);
   endtask

   function automatic void median_mad(input logic [15:0] st[MAX_PAIRS], input int unsigned n,
                                      output int unsigned med, output int unsigned mad);
      int unsigned v[$];
      int unsigned dv[$];
      int unsigned d;
      for (int i = 0; i < n; i++) v.insert(v.size(), st[i]);
      v.sort();
      med = (n % 2) ? 2 * v[n/2] : v[n/2-1] + v[n/2];
      for (int i = 0; i < n; i++) begin
         d = 2 * st[i];
         dv.insert(dv.size(), d >= med ? d - med : med - d);
      end
      dv.sort();
      mad = (n % 2) ? 2 * dv[n/2] : dv[n/2-1] + dv[n/2];
   endfunction

   task automatic predict_vote(input pair_rec_type p);
      verdict_type v;
      int unsigned mt, mr, at, ar, req;
      bit enough, sides, tight, stable, st;
      mt = 0; mr = 0; at = 0; ar = 0;
      if (p.pv && n_valid < MAX_PAIRS) begin
         n_valid++;
         if (p.off < 0) n_left++;
         else if (p.off != 0) n_right++;
         if (!p.pc || !p.pf) n_contra++;
         else begin
            if (n_meas < MAX_PAIRS) begin
               t_store[n_meas] = p.tr;
               r_store[n_meas] = p.rr;
               n_meas++;
            end
            if (p.tr <= 2 * dist_thr && p.rr <= 2 * ang_thr) n_support++;
            if (p.tr > 4 * dist_thr || p.rr > 4 * ang_thr) n_contra++;
         end
      end
      if (!p.last) return;
      st = n_meas > 0;
      if (st) begin
         median_mad(t_store, n_meas, mt, at);
         median_mad(r_store, n_meas, mr, ar);
      end
      enough = n_valid >= 4;
      sides = n_left > 0 || n_right > 0;
      req = (3 * n_valid + 3) / 4;
      tight = st && mt <= 4 * dist_thr && mr <= 4 * ang_thr;
      stable = !st || (at <= 4 * dist_thr && ar <= 4 * ang_thr);
      if (enough && n_contra > n_valid / 2) begin
         v.dec = DEC_REJECT; v.rsn = RSN_CONTRADICTION;
      end else if (enough && sides && n_support >= req && tight && stable && n_contra == 0) begin
         v.dec = DEC_COMMIT; v.rsn = RSN_CONSENSUS;
      end else begin
         v.dec = DEC_DEFER;
         v.rsn = (n_valid < 4) ? RSN_INSUFFICIENT : (n_contra > 0) ? RSN_UNSTABLE : RSN_WEAK;
      end
      v.vcnt = 5'(n_valid); v.lcnt = 5'(n_left); v.rcnt = 5'(n_right); v.ccnt = 5'(n_contra);
      v.med_t = 17'(mt); v.med_r = 17'(mr); v.mad_t = 18'(at); v.mad_r = 18'(ar);
      v.stats = st;
      expected_verdicts.insert(expected_verdicts.size(), v);
      n_meas = 0; n_valid = 0; n_left = 0; n_right = 0; n_contra = 0; n_support = 0;
   endtask

   // driver
   int req_gap = 0;
   initial begin
      req_if.valid = 0; req_if.pair_valid = 0; req_if.pair_converged = 0;
      req_if.deltas_finite = 0; req_if.pair_offset = 0; req_if.translation_residual = 0;
      req_if.rotation_residual = 0; req_if.last_pair = 0;
   end

   bit req_taken;
   always @(posedge clock) req_taken <= !reset && req_if.valid && req_if.ready;

   always @(negedge clock) begin
      pair_rec_type p;
      if (!reset) begin
         if (req_taken || !req_if.valid) begin
            if (req_taken) req_gap = $urandom_range(0, 16) * ($urandom_range(0, 3) != 0);
            if (req_gap > 0 || pending_pairs.size() == 0 || wait_drain) begin
               req_if.valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end else begin
               p = pending_pairs.pop_front();
               if (p.pv === 1'bx) begin
                  req_if.valid <= 1'b0;  // pause marker: wait for drain
                  wait_drain = 1;
               end else begin
                  req_if.valid <= 1'b1;
                  req_if.pair_valid <= p.pv; req_if.pair_converged <= p.pc;
                  req_if.deltas_finite <= p.pf; req_if.pair_offset <= p.off;
                  req_if.translation_residual <= p.tr; req_if.rotation_residual <= p.rr;
                  req_if.last_pair <= p.last;
                  predict_vote(p);
               end
            end
         end
      end
   end

   // receiver
   int rsp_gap = 0;
   bit rsp_taken;
   initial rsp_if.ready = 1'b0;
   always @(posedge clock) rsp_taken <= !reset && rsp_if.valid && rsp_if.ready;

   always @(negedge clock) begin
      if (rsp_taken) rsp_gap = $urandom_range(0, 16);
      if (hold_rsp) rsp_if.ready <= 1'b0;
      else if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("verdict beat with no expectation");
            errors++;
         end else begin
            e = expected_verdicts.pop_front();
            if (rsp_if.decision !== e.dec) begin
               $error("decision exp %0d got %0d", e.dec, rsp_if.decision); errors++; end
            if (rsp_if.reason_code !== e.rsn) begin
               $error("reason_code exp %0d got %0d", e.rsn, rsp_if.reason_code); errors++; end
            if (rsp_if.valid_count !== e.vcnt) begin
               $error("valid_count exp %0d got %0d", e.vcnt, rsp_if.valid_count); errors++; end
            if (rsp_if.left_count !== e.lcnt) begin
               $error("left_count exp %0d got %0d", e.lcnt, rsp_if.left_count); errors++; end
            if (rsp_if.right_count !== e.rcnt) begin
               $error("right_count exp %0d got %0d", e.rcnt, rsp_if.right_count); errors++; end
            if (rsp_if.conflict_count !== e.ccnt) begin
               $error("conflict_count exp %0d got %0d", e.ccnt,
                      rsp_if.conflict_count); errors++; end
            if (rsp_if.median_translation !== e.med_t) begin
               $error("median_translation exp %0d got %0d", e.med_t,
                      rsp_if.median_translation); errors++; end
            if (rsp_if.median_rotation !== e.med_r) begin
               $error("median_rotation exp %0d got %0d", e.med_r,
                      rsp_if.median_rotation); errors++; end
            if (rsp_if.spread_translation !== e.mad_t) begin
               $error("spread_translation exp %0d got %0d", e.mad_t,
                      rsp_if.spread_translation); errors++; end
            if (rsp_if.spread_rotation !== e.mad_r) begin
               $error("spread_rotation exp %0d got %0d", e.mad_r,
                      rsp_if.spread_rotation); errors++; end
            if (rsp_if.stats_valid !== e.stats) begin
               $error("stats_valid exp %0d got %0d", e.stats, rsp_if.stats_valid); errors++; end
         end
      end
   end

   function automatic pair_rec_type make_pair(bit pv, bit pc, bit pf, int off,
                                              int tr, int rr, bit last);
      pair_rec_type p;
      p.pv = pv; p.pc = pc; p.pf = pf; p.off = 5'(off); p.tr = 16'(tr); p.rr = 16'(rr);
      p.last = last;
      return p;
   endfunction

   function automatic int pick_res(int unsigned thr);
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(0, 3) == 0 ? 65535 : 0;
         default: return $urandom_range(0, (thr * 5 > 65535) ? 65535 : thr * 5);
      endcase
   endfunction

   task automatic add_random_set(int unsigned dt, int unsigned at);
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 9);
      for (int i = 0; i < n; i++) begin
         enqueue_pair(make_pair($urandom_range(0, 7) != 0,
            $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
            $urandom_range(0, 16) - 8, pick_res(dt), pick_res(at), i == n - 1));
      end
   endtask

   task automatic drain();
      while (pending_pairs.size() > 0 || req_if.valid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DISTANCE) dist_thr = val; else ang_thr = val;
   endtask

   pair_rec_type pause_mark;
   int unsigned cfg_d[5] = '{1000, 0, 65535, 50, 3000};
   int unsigned cfg_a[5] = '{175, 65535, 0, 20, 500};

   initial begin
      pause_mark.pv = 1'bx;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // directed: extremes, each verdict, empty and invalid sets
      enqueue_pair(make_pair(0, 0, 0, 0, 0, 0, 1));
      enqueue_pair(make_pair(1, 1, 1, 0, 65535, 65535, 1));
      for (int i = 0; i < 5; i++)
         enqueue_pair(make_pair(1, 1, 1, i % 2 ? -8 : 8, 100 + i, 50 + i, i == 4));
      for (int i = 0; i < 4; i++)
         enqueue_pair(make_pair(1, i > 0, 1, -1, 10, 10, i == 3));
      for (int i = 0; i < 4; i++)
         enqueue_pair(make_pair(1, 1, i != 2, 7, 5000, 40, i == 3));
      for (int i = 0; i < 4; i++)
         enqueue_pair(make_pair(1, 1, 1, 0, 10, 10, i == 3));
      drain();
      for (int c = 0; c < 5; c++) begin
         write_csr(CSR_DISTANCE, cfg_d[c]);
         write_csr(CSR_ANGLE, cfg_a[c]);
         if (c == 1) begin
            // long overflow set
            for (int i = 0; i < 20; i++)
               enqueue_pair(make_pair(1, 1, 1, $urandom_range(0, 16) - 8,
                  $urandom_range(0, 65535), $urandom_range(0, 65535), i == 19));
         end
         while (pending_pairs.size() < 230) add_random_set(cfg_d[c], cfg_a[c]);
         if (c == 2) begin
            enqueue_pair(pause_mark);
            for (int i = 0; i < 40; i++) add_random_set(cfg_d[c], cfg_a[c]);
         end
         if (c == 3) begin
            hold_rsp = 1;
            fork begin
               repeat (3000) @(posedge clock);
               hold_rsp = 0;
            end join_none
         end
         drain();
      end
      if (errors == 0) $display("loop_consensus_vote_unit verification clean");
      else $display("loop_consensus_vote_unit verification failed");
      $finish;
   end

   // pause marker release: resume once all verdicts are back
   always @(posedge clock)
      if (wait_drain && expected_verdicts.size() == 0) wait_drain <= 0;

   initial begin
      #4000000;
      $display("loop_consensus_vote_unit verification failed");
      $finish;
   end
endmodule

/* sim.f */
rtl/lcv_pkg.sv
rtl/lcv_chan_if.sv
rtl/lcv_ctrl.sv
rtl/lcv_datapath.sv
rtl/loop_consensus_vote_unit.sv
tb/loop_consensus_vote_unit_tb.sv
